// File: sv/rhc_pkg.sv
// shared types and constants of the rgb/hsv color converter
package rhc_pkg;

	// operation codes carried on cmd
	typedef enum logic [2:0] {
		CMD_RGB2HSV = 3'd0,
		CMD_HSV2RGB = 3'd1,
		CMD_SET_HUE = 3'd2,
		CMD_SET_SAT = 3'd3,
		CMD_SET_BRI = 3'd4
	} cmd_t;

	localparam logic [8:0] HUE_FULL  = 9'd360;
	localparam logic [8:0] HUE_GREEN = 9'd120;
	localparam logic [8:0] HUE_BLUE  = 9'd240;
	localparam logic [7:0] UNIT_SAT  = 8'd255;

	// hue divider: dividend below 60*255+255, quotient below 64
	localparam int HUE_NW = 14;
	localparam int HUE_DW = 8;
	localparam int HUE_QW = 6;

	// rgb divider lanes: p (or saturation), q, t
	localparam int RGB_NW = 23;
	localparam int RGB_DW = 15;
	localparam int RGB_QW = 8;
	localparam int RGB_LN = 3;

	// side data that travels with the hue division
	typedef struct packed {
		logic [2:0] cmd;
		logic [8:0] hue_in;
		logic [7:0] sat_in;
		logic [7:0] bri_in;
		logic [7:0] mx;
		logic [7:0] d;
		logic [8:0] base;
		logic       neg;
	} hue_side_t;

	// pixel handed from the hue section to the rgb section
	typedef struct packed {
		logic [2:0] cmd;
		logic [8:0] hue;
		logic [7:0] sat_in;
		logic [7:0] bri_in;
		logic [7:0] mx;
		logic [7:0] d;
	} pix_t;

	// side data that travels with the p/q/t division
	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] sector;
		logic [7:0] v;
		logic [8:0] hue;
		logic [7:0] mx;
		logic       grey;
	} rgb_side_t;

endpackage

// File: sv/rgb_hsv_color_converter.sv
// Per-pixel RGB/HSV converter: cmd selects RGB to HSV, HSV to RGB, or a new
// hue, saturation or brightness for an RGB pixel. It takes one pixel every
// clock cycle while the output is not held. It has 10 stages in the hue
// section (channel extremes, sector and difference, dividend setup, a
// six-stage hue divider, hue select) and 13 in the rgb section (sector split,
// two multiply stages, dividend setup, an eight-stage three-lane divider and
// the output register). Every stage has its own valid bit, so a held output
// only stops the stages that are full behind it.
module rgb_hsv_color_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [8:0] hue_in,
	input  logic [7:0] sat_in,
	input  logic [7:0] bright_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [8:0] hue_out,
	output logic [7:0] sat_out,
	output logic [7:0] bright_out
);

	logic          mid_valid;
	logic          mid_ready;
	rhc_pkg::pix_t mid_pix;

	// hue section
	rhc_hue u_hue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.hue_in   (hue_in),
		.sat_in   (sat_in),
		.bright_in(bright_in),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.pix      (mid_pix)
	);

	// rgb section
	rhc_rgb u_rgb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.pix       (mid_pix),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.bright_out(bright_out)
	);

`ifndef SYNTHESIS
	// a taken output never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n) out_ready |-> in_ready)
		else $error("input stalled while output is taken");

	// hsv results never carry rgb values
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (hue_out != 9'd0 || sat_out != 8'd0 || bright_out != 8'd0))
		|-> (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
		else $error("hsv and rgb fields both set");

	// hue stays below a full turn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue_out < 9'd360))
		else $error("hue out of range");

	// a black pixel has no saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bright_out == 8'd0) |-> (sat_out == 8'd0))
		else $error("saturation without brightness");
`endif

endmodule

// File: sv/rhc_div.sv
// pipelined restoring divider, one quotient bit per stage, one or more lanes
module rhc_div #(
	parameter int NW = 14,
	parameter int DW = 8,
	parameter int QW = 6,
	parameter int LN = 1,
	parameter int SW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [LN-1:0][NW-1:0]   num,
	input  logic [LN-1:0][DW-1:0]   den,
	input  logic [SW-1:0]           side_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [LN-1:0][QW-1:0]   quo,
	output logic [SW-1:0]           side_out
);

	localparam int CW = NW + DW + QW;

	logic [QW:0]                   rdy;
	logic [QW-1:0]                 vld_q;
	logic [QW-1:0][LN-1:0][NW-1:0] rem_s;
	logic [QW-1:0][LN-1:0][DW-1:0] den_s;
	logic [QW-1:0][LN-1:0][QW-1:0] quo_s;
	logic [QW-1:0][SW-1:0]         side_s;

	assign rdy[QW] = out_ready;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                  pv;
		logic [LN-1:0][NW-1:0] prem;
		logic [LN-1:0][DW-1:0] pden;
		logic [LN-1:0][QW-1:0] pquo;
		logic [SW-1:0]         pside;
		logic [LN-1:0][CW-1:0] sh;
		logic [LN-1:0][NW-1:0] nrem;
		logic [LN-1:0][QW-1:0] nquo;

		// previous stage or the input port
		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = num;
			assign pden  = den;
			assign pquo  = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_q[k-1];
			assign prem  = rem_s[k-1];
			assign pden  = den_s[k-1];
			assign pquo  = quo_s[k-1];
			assign pside = side_s[k-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			for (int l = 0; l < LN; l++) begin
				sh[l]   = CW'(pden[l]) << (QW - 1 - k);
				nrem[l] = prem[l];
				nquo[l] = pquo[l];
				if (CW'(prem[l]) >= sh[l]) begin
					nrem[l] = NW'(CW'(prem[l]) - sh[l]);
					nquo[l] = pquo[l] | (QW'(1) << (QW - 1 - k));
				end
			end
		end

		assign rdy[k] = !vld_q[k] || rdy[k+1];

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= pv;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (rdy[k] && pv) begin
				rem_s[k]  <= nrem;
				den_s[k]  <= pden;
				quo_s[k]  <= nquo;
				side_s[k] <= pside;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[QW-1];
	assign quo       = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

// File: sv/rhc_hue.sv
// hue section: channel extremes, hue division and hue selection
module rhc_hue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    cmd,
	input  logic [7:0]    red_in,
	input  logic [7:0]    green_in,
	input  logic [7:0]    blue_in,
	input  logic [8:0]    hue_in,
	input  logic [7:0]    sat_in,
	input  logic [7:0]    bright_in,
	output logic          out_valid,
	input  logic          out_ready,
	output rhc_pkg::pix_t pix
);

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: max and min of the channels
	logic [7:0] mx1, mn1, mrg, nrg;
	logic [2:0] cmd_s1;
	logic [7:0] r_s1, g_s1, b_s1, mx_s1, mn_s1, sat_s1, bri_s1;
	logic [8:0] hue_s1;

	always_comb begin
		mrg = (red_in > green_in) ? red_in : green_in;
		nrg = (red_in < green_in) ? red_in : green_in;
		mx1 = (mrg > blue_in) ? mrg : blue_in;
		mn1 = (nrg < blue_in) ? nrg : blue_in;
	end

	assign rdy1 = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cmd_s1 <= cmd;
			r_s1   <= red_in;
			g_s1   <= green_in;
			b_s1   <= blue_in;
			mx_s1  <= mx1;
			mn_s1  <= mn1;
			hue_s1 <= hue_in;
			sat_s1 <= sat_in;
			bri_s1 <= bright_in;
		end
	end

	// stage 2: hue sector of the largest channel and signed difference
	rhc_pkg::hue_side_t side2, side_s2;
	logic [7:0] pos2, neg2, diff2, diff_s2;

	always_comb begin
		side2.cmd    = cmd_s1;
		side2.hue_in = hue_s1;
		side2.sat_in = sat_s1;
		side2.bri_in = bri_s1;
		side2.mx     = mx_s1;
		side2.d      = mx_s1 - mn_s1;
		if (r_s1 == mx_s1) begin
			side2.base = '0;
			pos2       = g_s1;
			neg2       = b_s1;
		end else if (g_s1 == mx_s1) begin
			side2.base = rhc_pkg::HUE_GREEN;
			pos2       = b_s1;
			neg2       = r_s1;
		end else begin
			side2.base = rhc_pkg::HUE_BLUE;
			pos2       = r_s1;
			neg2       = g_s1;
		end
		side2.neg = (pos2 < neg2);
		diff2     = side2.neg ? (neg2 - pos2) : (pos2 - neg2);
	end

	assign rdy2 = !v_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			side_s2 <= side2;
			diff_s2 <= diff2;
		end
	end

	// stage 3: dividend 60*diff, biased for a ceiling when negative
	rhc_pkg::hue_side_t side_s3;
	logic [rhc_pkg::HUE_NW-1:0] x3, num3, num_s3;
	logic div_ready;

	always_comb begin
		x3   = rhc_pkg::HUE_NW'(diff_s2) * rhc_pkg::HUE_NW'(60);
		num3 = side_s2.neg ? (x3 + rhc_pkg::HUE_NW'(side_s2.d) - rhc_pkg::HUE_NW'(1)) : x3;
	end

	assign rdy3 = !v_s3 || div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			side_s3 <= side_s2;
			num_s3  <= num3;
		end
	end

	// hue division by the channel spread
	logic                       dv;
	logic [rhc_pkg::HUE_QW-1:0] dq;
	rhc_pkg::hue_side_t         dside;

	rhc_div #(
		.NW(rhc_pkg::HUE_NW),
		.DW(rhc_pkg::HUE_DW),
		.QW(rhc_pkg::HUE_QW),
		.LN(1),
		.SW($bits(rhc_pkg::hue_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (div_ready),
		.num      (num_s3),
		.den      (side_s3.d),
		.side_in  (side_s3),
		.out_valid(dv),
		.out_ready(rdy4),
		.quo      (dq),
		.side_out (dside)
	);

	// stage 4: final hue, from the pixel or from the port
	rhc_pkg::pix_t pix4, pix_s4;
	logic [8:0] q9, rgb_hue;

	always_comb begin
		q9 = 9'(dq);
		if (dside.d == '0) begin
			rgb_hue = '0;
		end else if (!dside.neg) begin
			rgb_hue = dside.base + q9;
		end else if (dside.base == '0) begin
			rgb_hue = rhc_pkg::HUE_FULL - q9;
		end else begin
			rgb_hue = dside.base - q9;
		end
		pix4.cmd    = dside.cmd;
		pix4.sat_in = dside.sat_in;
		pix4.bri_in = dside.bri_in;
		pix4.mx     = dside.mx;
		pix4.d      = dside.d;
		case (dside.cmd)
			rhc_pkg::CMD_HSV2RGB, rhc_pkg::CMD_SET_HUE: begin
				pix4.hue = (dside.hue_in >= rhc_pkg::HUE_FULL) ? '0 : dside.hue_in;
			end
			default: begin
				pix4.hue = rgb_hue;
			end
		endcase
	end

	assign rdy4 = !v_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && dv) begin
			pix_s4 <= pix4;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s4;
	assign pix       = pix_s4;

endmodule

// File: sv/rhc_rgb.sv
// rgb section: sector split, p/q/t products, divisions and output mux
module rhc_rgb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rhc_pkg::pix_t pix,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    red_out,
	output logic [7:0]    green_out,
	output logic [7:0]    blue_out,
	output logic [8:0]    hue_out,
	output logic [7:0]    sat_out,
	output logic [7:0]    bright_out
);

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: sector, offset in sector, saturation ratio and value
	logic [2:0] sec1;
	logic [8:0] lo1;
	logic [7:0] sn1, sd1, v1;
	logic       grey1;
	logic [2:0] cmd_s1, sec_s1;
	logic [5:0] f_s1;
	logic [7:0] sn_s1, sd_s1, v_s1d, mx_s1, d_s1;
	logic [8:0] hue_s1;
	logic       grey_s1;

	always_comb begin
		sec1 = 3'd0;
		if (pix.hue >= 9'd60)  sec1 = 3'd1;
		if (pix.hue >= 9'd120) sec1 = 3'd2;
		if (pix.hue >= 9'd180) sec1 = 3'd3;
		if (pix.hue >= 9'd240) sec1 = 3'd4;
		if (pix.hue >= 9'd300) sec1 = 3'd5;
		case (sec1)
			3'd0:    lo1 = 9'd0;
			3'd1:    lo1 = 9'd60;
			3'd2:    lo1 = 9'd120;
			3'd3:    lo1 = 9'd180;
			3'd4:    lo1 = 9'd240;
			default: lo1 = 9'd300;
		endcase
		grey1 = (pix.d == '0);
		case (pix.cmd)
			rhc_pkg::CMD_HSV2RGB: begin
				sn1 = pix.sat_in;
				sd1 = rhc_pkg::UNIT_SAT;
				v1  = pix.bri_in;
			end
			rhc_pkg::CMD_SET_SAT: begin
				sn1 = pix.sat_in;
				sd1 = rhc_pkg::UNIT_SAT;
				v1  = pix.mx;
			end
			rhc_pkg::CMD_SET_BRI: begin
				sn1 = pix.d;
				sd1 = grey1 ? 8'd1 : pix.mx;
				v1  = pix.bri_in;
			end
			default: begin
				sn1 = pix.d;
				sd1 = grey1 ? 8'd1 : pix.mx;
				v1  = pix.mx;
			end
		endcase
	end

	assign rdy1 = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cmd_s1  <= pix.cmd;
			sec_s1  <= sec1;
			f_s1    <= 6'(pix.hue - lo1);
			sn_s1   <= sn1;
			sd_s1   <= sd1;
			v_s1d   <= v1;
			mx_s1   <= pix.mx;
			d_s1    <= pix.d;
			hue_s1  <= pix.hue;
			grey_s1 <= grey1;
		end
	end

	// stage 2: sn*f, sn*(60-f) and 60*sd
	logic [2:0]  cmd_s2, sec_s2;
	logic [7:0]  sn_s2, sd_s2, v_s2d, mx_s2, d_s2;
	logic [8:0]  hue_s2;
	logic        grey_s2;
	logic [13:0] snf_s2, snr_s2, d60_s2;

	assign rdy2 = !v_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			cmd_s2  <= cmd_s1;
			sec_s2  <= sec_s1;
			sn_s2   <= sn_s1;
			sd_s2   <= sd_s1;
			v_s2d   <= v_s1d;
			mx_s2   <= mx_s1;
			d_s2    <= d_s1;
			hue_s2  <= hue_s1;
			grey_s2 <= grey_s1;
			snf_s2  <= 14'(sn_s1) * 14'(f_s1);
			snr_s2  <= 14'(sn_s1) * (14'd60 - 14'(f_s1));
			d60_s2  <= 14'(sd_s1) * 14'd60;
		end
	end

	// stage 3: value times the three weights
	logic [2:0]  cmd_s3, sec_s3;
	logic [7:0]  sd_s3, v_s3d, mx_s3, d_s3;
	logic [8:0]  hue_s3;
	logic        grey_s3;
	logic [13:0] d60_s3;
	logic [15:0] ap_s3;
	logic [21:0] aq_s3, at_s3;

	assign rdy3 = !v_s3 || rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			cmd_s3  <= cmd_s2;
			sec_s3  <= sec_s2;
			sd_s3   <= sd_s2;
			v_s3d   <= v_s2d;
			mx_s3   <= mx_s2;
			d_s3    <= d_s2;
			hue_s3  <= hue_s2;
			grey_s3 <= grey_s2;
			d60_s3  <= d60_s2;
			ap_s3   <= 16'(v_s2d) * 16'(sd_s2 - sn_s2);
			aq_s3   <= 22'(v_s2d) * 22'(d60_s2 - snf_s2);
			at_s3   <= 22'(v_s2d) * 22'(d60_s2 - snr_s2);
		end
	end

	// stage 4: round-half-up dividends and doubled divisors
	logic [16:0] np4;
	logic [8:0]  dp4;
	logic [rhc_pkg::RGB_LN-1:0][rhc_pkg::RGB_NW-1:0] num4, num_s4;
	logic [rhc_pkg::RGB_LN-1:0][rhc_pkg::RGB_DW-1:0] den4, den_s4;
	rhc_pkg::rgb_side_t side4, side_s4;

	always_comb begin
		if (cmd_s3 == rhc_pkg::CMD_RGB2HSV) begin
			np4 = 17'(d_s3) * 17'd510 + 17'(mx_s3);
			dp4 = {mx_s3, 1'b0};
		end else begin
			np4 = {ap_s3, 1'b0} + 17'(sd_s3);
			dp4 = {sd_s3, 1'b0};
		end
		num4[0] = rhc_pkg::RGB_NW'(np4);
		den4[0] = rhc_pkg::RGB_DW'(dp4);
		num4[1] = {aq_s3, 1'b0} + rhc_pkg::RGB_NW'(d60_s3);
		den4[1] = {d60_s3, 1'b0};
		num4[2] = {at_s3, 1'b0} + rhc_pkg::RGB_NW'(d60_s3);
		den4[2] = {d60_s3, 1'b0};
		side4.cmd    = cmd_s3;
		side4.sector = sec_s3;
		side4.v      = v_s3d;
		side4.hue    = hue_s3;
		side4.mx     = mx_s3;
		side4.grey   = grey_s3;
	end

	logic div_ready;

	assign rdy4 = !v_s4 || div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			num_s4  <= num4;
			den_s4  <= den4;
			side_s4 <= side4;
		end
	end

	// three-lane division: p or saturation, q, t
	logic                                            dv;
	logic [rhc_pkg::RGB_LN-1:0][rhc_pkg::RGB_QW-1:0] dq;
	rhc_pkg::rgb_side_t                              dside;

	rhc_div #(
		.NW(rhc_pkg::RGB_NW),
		.DW(rhc_pkg::RGB_DW),
		.QW(rhc_pkg::RGB_QW),
		.LN(rhc_pkg::RGB_LN),
		.SW($bits(rhc_pkg::rgb_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_ready (div_ready),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.out_valid(dv),
		.out_ready(rdy5),
		.quo      (dq),
		.side_out (dside)
	);

	// stage 5: result register with sector mux
	logic [7:0] r5, g5, b5, s5, bv5, vv, pp, qq, tt;
	logic [8:0] h5;
	logic [7:0] r_s5, g_s5, b_s5, s_s5, bv_s5;
	logic [8:0] h_s5;

	always_comb begin
		vv  = dside.v;
		pp  = dq[0];
		qq  = dq[1];
		tt  = dq[2];
		r5  = '0;
		g5  = '0;
		b5  = '0;
		h5  = '0;
		s5  = '0;
		bv5 = '0;
		case (dside.cmd)
			rhc_pkg::CMD_RGB2HSV: begin
				h5  = dside.hue;
				s5  = dside.grey ? 8'd0 : pp;
				bv5 = dside.mx;
			end
			rhc_pkg::CMD_HSV2RGB, rhc_pkg::CMD_SET_HUE, rhc_pkg::CMD_SET_SAT,
			rhc_pkg::CMD_SET_BRI: begin
				case (dside.sector)
					3'd0: begin r5 = vv; g5 = tt; b5 = pp; end
					3'd1: begin r5 = qq; g5 = vv; b5 = pp; end
					3'd2: begin r5 = pp; g5 = vv; b5 = tt; end
					3'd3: begin r5 = pp; g5 = qq; b5 = vv; end
					3'd4: begin r5 = tt; g5 = pp; b5 = vv; end
					default: begin r5 = vv; g5 = pp; b5 = qq; end
				endcase
			end
			default: begin
				r5 = '0;
			end
		endcase
	end

	assign rdy5 = !v_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && dv) begin
			r_s5  <= r5;
			g_s5  <= g5;
			b_s5  <= b5;
			h_s5  <= h5;
			s_s5  <= s5;
			bv_s5 <= bv5;
		end
	end

	assign in_ready   = rdy1;
	assign out_valid  = v_s5;
	assign red_out    = r_s5;
	assign green_out  = g_s5;
	assign blue_out   = b_s5;
	assign hue_out    = h_s5;
	assign sat_out    = s_s5;
	assign bright_out = bv_s5;

endmodule
